>>> rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared widths, operator codes, result codes, payload structs and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int DATA_W      = 32;
  localparam int TAG_W       = 8;
  localparam int OPC_W       = 5;
  localparam int VAR_W       = 4;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int SHAMT_W     = $clog2(DATA_W);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_OPER = 1'b1;

  localparam logic [OPC_W-1:0] OP_END    = 5'd0;
  localparam logic [OPC_W-1:0] OP_NEG    = 5'd1;
  localparam logic [OPC_W-1:0] OP_LNOT   = 5'd2;
  localparam logic [OPC_W-1:0] OP_NOT    = 5'd3;
  localparam logic [OPC_W-1:0] OP_ADD    = 5'd4;
  localparam logic [OPC_W-1:0] OP_SUB    = 5'd5;
  localparam logic [OPC_W-1:0] OP_MUL    = 5'd6;
  localparam logic [OPC_W-1:0] OP_DIV    = 5'd7;
  localparam logic [OPC_W-1:0] OP_MOD    = 5'd8;
  localparam logic [OPC_W-1:0] OP_SHL    = 5'd9;
  localparam logic [OPC_W-1:0] OP_SHR    = 5'd10;
  localparam logic [OPC_W-1:0] OP_EQ     = 5'd11;
  localparam logic [OPC_W-1:0] OP_NE     = 5'd12;
  localparam logic [OPC_W-1:0] OP_LT     = 5'd13;
  localparam logic [OPC_W-1:0] OP_LE     = 5'd14;
  localparam logic [OPC_W-1:0] OP_GT     = 5'd15;
  localparam logic [OPC_W-1:0] OP_GE     = 5'd16;
  localparam logic [OPC_W-1:0] OP_OR     = 5'd17;
  localparam logic [OPC_W-1:0] OP_AND    = 5'd18;
  localparam logic [OPC_W-1:0] OP_XOR    = 5'd19;
  localparam logic [OPC_W-1:0] OP_LOR    = 5'd20;
  localparam logic [OPC_W-1:0] OP_LAND   = 5'd21;
  localparam logic [OPC_W-1:0] OP_ASSIGN = 5'd22;
  localparam logic [OPC_W-1:0] OP_PASS   = 5'd23;

  localparam logic [VAR_W-1:0] VAR_TAG_HI = 4'h9;

  typedef enum logic [2:0] {
    RES_FINAL     = 3'd0,
    RES_STORE_VAR = 3'd1,
    RES_STORE_REF = 3'd2,
    RES_OVERFLOW  = 3'd3,
    RES_UNDERFLOW = 3'd4,
    RES_NO_TARGET = 3'd5
  } res_kind_t;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] push_value;
    logic [TAG_W-1:0]         target_tag;
    logic [OPC_W-1:0]         operator_code;
  } item_t;

  typedef struct packed {
    res_kind_t                result_kind;
    logic signed [DATA_W-1:0] result_value;
    logic [VAR_W-1:0]         variable_index;
    logic [TAG_W-1:0]         reference_tag;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic has_result;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/rpn_stack_expression_evaluator.sv
// ----------------------------------------------------------------------------
// RPN stack expression evaluator
// Postfix evaluator on an eight-entry operand stack with store requests.
// ----------------------------------------------------------------------------
// The item channel takes push and operator items; the result channel gives
// at most one request per item: a final value, a store to a variable or to a
// reference, or an overflow, underflow or missing-target flag.
// After acceptance an item passes through decode, a divide where needed, and
// commit before the next item can be accepted, and its request is shown in
// the cycle after its commit. Divide and modulo wait for the divider, which
// resolves one quotient bit per cycle.
// Reset empties the stack and drops any request that has not been taken.
// While the receiver stalls, the waiting request is held in the output
// register and further items that raise no request are still accepted; an
// item that raises a request waits at commit until the register is free.
// ----------------------------------------------------------------------------
module rpn_stack_expression_evaluator import rpn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rpn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> rtl/core/rpn_div.sv
// ----------------------------------------------------------------------------
// RPN divider
// Signed truncating divide and remainder, one restoring step per cycle on
// the magnitudes, with the signs applied to the finished result.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder
);

  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W-1:0]    dividend_q;
  logic                 a_neg;
  logic                 b_neg;
  logic                 b_zero;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;

  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DATA_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_neg      <= dividend[DATA_W-1];
      b_neg      <= divisor[DATA_W-1];
      b_zero     <= (divisor == '0);
      dividend_q <= dividend;
      rem        <= '0;
      quo        <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs        <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    end else if (running) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
      end else begin
        rem <= shifted[DATA_W-1:0];
      end
      quo <= {quo[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  always_comb begin
    if (b_zero) begin
      quotient  = '0;
      remainder = dividend_q;
    end else begin
      quotient  = (a_neg ^ b_neg) ? (~quo + 1'b1) : quo;
      remainder = a_neg ? (~rem + 1'b1) : rem;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_clears_done: assert property (@(posedge clk) disable iff (rst)
    start |=> !done)
    else $error("Divider reports done directly after a start.");
  a_run_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(running && done))
    else $error("Divider is running and done at once.");
`endif

endmodule

>>> rtl/core/rpn_dp.sv
// ----------------------------------------------------------------------------
// RPN datapath
// Item register, shifting operand stack, operator unit, divider and the
// result register that holds one request for the receiver.
// ----------------------------------------------------------------------------
module rpn_dp import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);

  item_t              item_q;
  logic [DATA_W-1:0]  vals [STACK_DEPTH];
  logic [TAG_W:0]     tgts [STACK_DEPTH];
  logic [DEPTH_W-1:0] depth;

  logic              is_push;
  logic              is_end;
  logic              full;
  logic              do_push;
  logic              do_pop;
  logic              do_clear;
  logic              has_result;
  result_t           res_next;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] alu;
  logic [DATA_W-1:0] top_val;
  logic [TAG_W:0]    top_tgt;
  logic              big_shift;
  logic              div_done;
  logic [DATA_W-1:0] quotient;
  logic [DATA_W-1:0] remainder;

  rpn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (a),
    .divisor   (b),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign a         = vals[1];
  assign b         = vals[0];
  assign is_push   = (item_q.kind == KIND_PUSH);
  assign is_end    = !is_push && (item_q.operator_code == OP_END);
  assign full      = (depth >= DEPTH_W'(STACK_DEPTH));
  assign big_shift = |b[DATA_W-1:SHAMT_W];

  always_comb begin
    case (item_q.operator_code)
      OP_NEG:  alu = ~b + 1'b1;
      OP_LNOT: alu = DATA_W'(b == '0);
      OP_NOT:  alu = ~b;
      OP_ADD:  alu = a + b;
      OP_SUB:  alu = a - b;
      OP_MUL:  alu = a * b;
      OP_DIV:  alu = quotient;
      OP_MOD:  alu = remainder;
      OP_SHL:  alu = big_shift ? '0 : (a << b[SHAMT_W-1:0]);
      OP_SHR:  alu = big_shift ? '0 : (a >> b[SHAMT_W-1:0]);
      OP_EQ:   alu = DATA_W'(a == b);
      OP_NE:   alu = DATA_W'(a != b);
      OP_LT:   alu = DATA_W'($signed(a) < $signed(b));
      OP_LE:   alu = DATA_W'($signed(a) <= $signed(b));
      OP_GT:   alu = DATA_W'($signed(a) > $signed(b));
      OP_GE:   alu = DATA_W'($signed(a) >= $signed(b));
      OP_OR:   alu = a | b;
      OP_AND:  alu = a & b;
      OP_XOR:  alu = a ^ b;
      OP_LOR:  alu = DATA_W'((a != '0) || (b != '0));
      OP_LAND: alu = DATA_W'((a != '0) && (b != '0));
      OP_PASS: alu = b;
      default: alu = '0;
    endcase
  end

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_clear   = 1'b0;
    has_result = 1'b0;
    top_val    = alu;
    top_tgt    = '0;
    res_next   = '{result_kind: RES_FINAL, result_value: '0,
                   variable_index: '0, reference_tag: '0};
    if (is_push) begin
      if (full) begin
        has_result           = 1'b1;
        res_next.result_kind = RES_OVERFLOW;
      end else begin
        do_push = 1'b1;
      end
    end else if (is_end) begin
      has_result = 1'b1;
      if (depth == '0) begin
        res_next.result_kind = RES_UNDERFLOW;
      end else begin
        do_clear              = 1'b1;
        res_next.result_value = b;
      end
    end else if (depth < DEPTH_W'(2)) begin
      has_result           = 1'b1;
      res_next.result_kind = RES_UNDERFLOW;
    end else if (item_q.operator_code == OP_ASSIGN) begin
      do_pop                = 1'b1;
      has_result            = 1'b1;
      top_val               = b;
      top_tgt               = tgts[1];
      res_next.result_value = b;
      if (!tgts[1][TAG_W]) begin
        res_next.result_kind = RES_NO_TARGET;
      end else if (tgts[1][TAG_W-1:TAG_W-VAR_W] == VAR_TAG_HI) begin
        res_next.result_kind    = RES_STORE_VAR;
        res_next.variable_index = tgts[1][VAR_W-1:0];
      end else begin
        res_next.result_kind   = RES_STORE_REF;
        res_next.reference_tag = tgts[1][TAG_W-1:0];
      end
    end else begin
      do_pop = 1'b1;
    end
  end

  assign stat.needs_div  = !is_push && !is_end && (depth >= DEPTH_W'(2)) &&
                           ((item_q.operator_code == OP_DIV) ||
                            (item_q.operator_code == OP_MOD));
  assign stat.has_result = has_result;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_push) begin
        vals[0] <= item_q.push_value;
        tgts[0] <= {1'b1, item_q.target_tag};
        for (int i = 1; i < STACK_DEPTH; i++) begin
          vals[i] <= vals[i-1];
          tgts[i] <= tgts[i-1];
        end
      end else if (do_pop) begin
        vals[0] <= top_val;
        tgts[0] <= top_tgt;
        for (int i = 1; i < STACK_DEPTH - 1; i++) begin
          vals[i] <= vals[i+1];
          tgts[i] <= tgts[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.commit) begin
      if (do_push) begin
        depth <= depth + 1'b1;
      end else if (do_pop) begin
        depth <= depth - 1'b1;
      end else if (do_clear) begin
        depth <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit && has_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && has_result) begin
      result <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("Stack depth is beyond the stack size.");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && has_result |-> !result_valid || result_ready)
    else $error("A request overwrites one that has not been taken.");
  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_clear |=> depth == '0)
    else $error("The stack is not empty after the end of an expression.");
`endif

endmodule

>>> rtl/core/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// RPN controller
// Sequences one item at a time: capture, decode, divide where needed, and
// commit once the result register can take the request.
// ----------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = stat.needs_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!stat.has_result || stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready    = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      S_DECODE: begin
        cmd.div_start = stat.needs_div;
      end
      S_DIV: begin
      end
      S_COMMIT: begin
        cmd.commit = !stat.has_result || stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule
